>>> sv/tot_pkg.sv
`timescale 1ns / 1ps
package tot_pkg;

   localparam int unsigned TOT_WAVEFORM_LENGTH = 1024;
   localparam int unsigned TOT_QUEUE_DEPTH = 2;

   localparam int TIME_W = 20;
   localparam int AMP_W = 16;
   localparam int WIN_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = AMP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LAST = 2'd2;

   localparam logic signed [AMP_W-1:0] THRESHOLD_RESET = '0;
   localparam logic [WIN_W-1:0] WINDOW_FIRST_RESET = '0;
   localparam logic [WIN_W-1:0] WINDOW_LAST_RESET = '1;

   typedef struct packed {
      logic [TIME_W-1:0] sample_time;
      logic signed [AMP_W-1:0] sample_amplitude;
      logic last_sample;
   } tot_req_type;

   typedef struct packed {
      logic found;
      logic [TIME_W-1:0] rise_time;
      logic [TIME_W-1:0] fall_time;
   } tot_rsp_type;

   // Work handed from the front to the back: an optional interpolation and
   // an optional end of waveform.
   typedef struct packed {
      logic interp;
      logic is_rise;
      logic finish;
      logic found;
      logic [TIME_W-1:0] t0;
      logic signed [AMP_W-1:0] a0;
      logic [TIME_W-1:0] t1;
      logic signed [AMP_W-1:0] a1;
      logic signed [AMP_W-1:0] thr;
   } tot_job_type;

   typedef struct packed {
      logic valid;
      logic [TIME_W-1:0] rise_time;
   } tot_fb_type;

endpackage

>>> sv/time_over_threshold_interp.sv
`timescale 1ns / 1ps
// Time over threshold with linear interpolation. Samples of a waveform enter
// one per cycle; the final sample of each waveform (last_sample set) yields
// one item with the interpolated rising and falling threshold crossing times,
// floored to whole picoseconds, or found = 0 and zero times if either crossing
// is missing. The front end checks each sample pair against the threshold and
// the index window in the cycle the sample arrives. Each crossing costs an
// interpolation in the back end: one multiply followed by a one-bit-per-cycle
// divider. After an upward crossing on any but the final sample the input
// holds full until the rise time is back, because the downward search
// compares against it. Other samples still enter one per cycle as long as
// the two-entry queue between front and back has room; it fills when
// crossings and waveform ends pile up behind an interpolation or when
// results are not popped, and the input then holds full as well. Another
// two-entry queue holds results that have not yet been popped.
// Configuration writes take effect on the next sample.
module time_over_threshold_interp #(
   parameter int unsigned WAVEFORM_LENGTH = tot_pkg::TOT_WAVEFORM_LENGTH
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input tot_pkg::tot_req_type req_data,
   output logic rsp_empty,
   input logic rsp_pop,
   output tot_pkg::tot_rsp_type rsp_data,
   input logic csr_write,
   input logic [tot_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [tot_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tot_pkg::*;

   logic signed [AMP_W-1:0] threshold_ff, threshold_in;
   logic [WIN_W-1:0] window_first_ff, window_first_in;
   logic [WIN_W-1:0] window_last_ff, window_last_in;

   logic job_push, job_full, job_pop, job_empty;
   tot_job_type job_wdata, job_rdata;
   tot_fb_type fb;
   logic out_push, out_full;
   tot_rsp_type out_data;

   always_comb begin
      threshold_in = threshold_ff;
      window_first_in = window_first_ff;
      window_last_in = window_last_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata;
            CSR_WINDOW_FIRST: window_first_in = csr_wdata[WIN_W-1:0];
            CSR_WINDOW_LAST: window_last_in = csr_wdata[WIN_W-1:0];
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         window_first_ff <= WINDOW_FIRST_RESET;
         window_last_ff <= WINDOW_LAST_RESET;
      end else begin
         threshold_ff <= threshold_in;
         window_first_ff <= window_first_in;
         window_last_ff <= window_last_in;
      end
   end

   tot_front #(
      .WAVEFORM_LENGTH(WAVEFORM_LENGTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .threshold(threshold_ff),
      .window_first(window_first_ff),
      .window_last(window_last_ff),
      .job_push(job_push),
      .job_data(job_wdata),
      .job_full(job_full),
      .fb(fb)
   );

   tot_fifo #(
      .WIDTH($bits(tot_job_type)),
      .DEPTH(TOT_QUEUE_DEPTH)
   ) u_job_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(job_wdata),
      .full(job_full),
      .pop(job_pop),
      .pop_data(job_rdata),
      .empty(job_empty)
   );

   tot_back u_back (
      .clock(clock),
      .reset(reset),
      .job_empty(job_empty),
      .job_data(job_rdata),
      .job_pop(job_pop),
      .fb(fb),
      .out_push(out_push),
      .out_data(out_data),
      .out_full(out_full)
   );

   tot_fifo #(
      .WIDTH($bits(tot_rsp_type)),
      .DEPTH(TOT_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .push_data(out_data),
      .full(out_full),
      .pop(rsp_pop),
      .pop_data(rsp_data),
      .empty(rsp_empty)
   );

`ifndef SYNTHESIS
   // The front never hands work to a full queue.
   a_job_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job pushed into a full queue");

   // The back only takes work that is there.
   a_job_no_underflow: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job popped from an empty queue");

   // A returned rise time always releases a stalled input.
   a_fb_releases: assert property (@(posedge clock) disable iff (reset)
      fb.valid |-> req_full)
      else $error("rise time returned while the input was not held");

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");
`endif

endmodule

>>> sv/tot_fifo.sv
`timescale 1ns / 1ps
module tot_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = tot_pkg::TOT_QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   input logic push,
   input logic [WIDTH-1:0] push_data,
   output logic full,
   input logic pop,
   output logic [WIDTH-1:0] pop_data,
   output logic empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/tot_front.sv
`timescale 1ns / 1ps
module tot_front #(
   parameter int unsigned WAVEFORM_LENGTH = tot_pkg::TOT_WAVEFORM_LENGTH
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input tot_pkg::tot_req_type req_data,
   input logic signed [tot_pkg::AMP_W-1:0] threshold,
   input logic [tot_pkg::WIN_W-1:0] window_first,
   input logic [tot_pkg::WIN_W-1:0] window_last,
   output logic job_push,
   output tot_pkg::tot_job_type job_data,
   input logic job_full,
   input tot_pkg::tot_fb_type fb
);
   import tot_pkg::*;

   localparam int IDX_W = $clog2(WAVEFORM_LENGTH + 1);
   localparam int CMP_W = (IDX_W > WIN_W) ? IDX_W : WIN_W;

   typedef enum logic [2:0] {
      PH_RISE = 3'b001,
      PH_FALL = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   phase_type phase_ff, phase_in, phase_cross;
   logic signed [AMP_W-1:0] prev_amp_ff, prev_amp_in;
   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [TIME_W-1:0] rise_time_ff, rise_time_in;
   logic wait_ff, wait_in;

   logic accept, in_window, rise_hit, fall_hit;

   assign req_full = wait_ff | job_full;
   assign accept = req_push & ~req_full;

   assign in_window = (CMP_W'(idx_ff) > CMP_W'(window_first))
                    && (CMP_W'(idx_ff) <= CMP_W'(window_last))
                    && (idx_ff != IDX_W'(WAVEFORM_LENGTH));

   assign rise_hit = in_window && (phase_ff == PH_RISE)
                   && (prev_amp_ff < threshold)
                   && (req_data.sample_amplitude >= threshold);
   // The falling search only opens once the rise time has come back.
   assign fall_hit = in_window && (phase_ff == PH_FALL)
                   && (req_data.sample_time > rise_time_ff)
                   && (prev_amp_ff >= threshold)
                   && (req_data.sample_amplitude < threshold);

   always_comb begin
      phase_cross = phase_ff;
      if (rise_hit) begin
         phase_cross = PH_FALL;
      end else if (fall_hit) begin
         phase_cross = PH_DONE;
      end
   end

   always_comb begin
      job_data.interp = rise_hit | fall_hit;
      job_data.is_rise = rise_hit;
      job_data.finish = req_data.last_sample;
      job_data.found = (phase_cross == PH_DONE);
      job_data.t0 = prev_time_ff;
      job_data.a0 = prev_amp_ff;
      job_data.t1 = req_data.sample_time;
      job_data.a1 = req_data.sample_amplitude;
      job_data.thr = threshold;
   end

   assign job_push = accept & (rise_hit | fall_hit | req_data.last_sample);

   always_comb begin
      prev_amp_in = prev_amp_ff;
      prev_time_in = prev_time_ff;
      idx_in = idx_ff;
      phase_in = phase_ff;
      rise_time_in = rise_time_ff;
      wait_in = wait_ff;
      if (fb.valid) begin
         rise_time_in = fb.rise_time;
         wait_in = 1'b0;
      end
      if (accept) begin
         prev_amp_in = req_data.sample_amplitude;
         prev_time_in = req_data.sample_time;
         if (req_data.last_sample) begin
            idx_in = '0;
            phase_in = PH_RISE;
         end else begin
            if (idx_ff != IDX_W'(WAVEFORM_LENGTH)) begin
               idx_in = idx_ff + 1'b1;
            end
            phase_in = phase_cross;
            if (rise_hit) begin
               wait_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_amp_ff <= '0;
         prev_time_ff <= '0;
         idx_ff <= '0;
         phase_ff <= PH_RISE;
         rise_time_ff <= '0;
         wait_ff <= 1'b0;
      end else begin
         prev_amp_ff <= prev_amp_in;
         prev_time_ff <= prev_time_in;
         idx_ff <= idx_in;
         phase_ff <= phase_in;
         rise_time_ff <= rise_time_in;
         wait_ff <= wait_in;
      end
   end

endmodule

>>> sv/tot_back.sv
`timescale 1ns / 1ps
module tot_back (
   input logic clock,
   input logic reset,
   input logic job_empty,
   input tot_pkg::tot_job_type job_data,
   output logic job_pop,
   output tot_pkg::tot_fb_type fb,
   output logic out_push,
   output tot_pkg::tot_rsp_type out_data,
   input logic out_full
);
   import tot_pkg::*;

   localparam int PROD_W = AMP_W + TIME_W;
   localparam int CNT_W = $clog2(TIME_W);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PREP = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIX  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   tot_job_type job_ff, job_in;
   logic [AMP_W-1:0] p_ff, p_in;
   logic [AMP_W-1:0] den_ff, den_in;
   logic [TIME_W-1:0] dmag_ff, dmag_in;
   logic neg_ff, neg_in;
   logic [AMP_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0] held_rise_ff, held_rise_in;
   logic [TIME_W-1:0] held_fall_ff, held_fall_in;

   logic signed [AMP_W:0] diff_p, diff_d;
   logic signed [TIME_W:0] dt;
   logic [TIME_W:0] dt_abs;
   logic [PROD_W-1:0] prod;
   logic [AMP_W:0] shifted;
   logic ge;
   logic [TIME_W-1:0] t_new;

   // Both crossings are normalized so that numerator and divisor are
   // non-negative; only the time difference keeps its sign.
   always_comb begin
      if (job_ff.is_rise) begin
         diff_p = (AMP_W+1)'(job_ff.thr) - (AMP_W+1)'(job_ff.a0);
         diff_d = (AMP_W+1)'(job_ff.a1) - (AMP_W+1)'(job_ff.a0);
      end else begin
         diff_p = (AMP_W+1)'(job_ff.a0) - (AMP_W+1)'(job_ff.thr);
         diff_d = (AMP_W+1)'(job_ff.a0) - (AMP_W+1)'(job_ff.a1);
      end
      dt = $signed({1'b0, job_ff.t1}) - $signed({1'b0, job_ff.t0});
      dt_abs = dt[TIME_W] ? -dt : dt;
   end

   assign prod = PROD_W'(p_ff) * PROD_W'(dmag_ff);

   // The product is below divisor times 2^TIME_W, so the top bits start
   // out as a valid partial remainder.
   assign shifted = {rem_ff, low_ff[TIME_W-1]};
   assign ge = (shifted >= {1'b0, den_ff});

   always_comb begin
      if (neg_ff) begin
         t_new = job_ff.t0 - low_ff - TIME_W'(rem_ff != '0);
      end else begin
         t_new = job_ff.t0 + low_ff;
      end
   end

   assign fb.valid = (state_ff == ST_FIX) && job_ff.is_rise && !job_ff.finish;
   assign fb.rise_time = t_new;

   assign job_pop = (state_ff == ST_IDLE) && !job_empty;
   assign out_push = (state_ff == ST_OUT) && !out_full;

   always_comb begin
      out_data.found = job_ff.found;
      out_data.rise_time = job_ff.found ? held_rise_ff : '0;
      out_data.fall_time = job_ff.found ? held_fall_ff : '0;
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      p_in = p_ff;
      den_in = den_ff;
      dmag_in = dmag_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      cnt_in = cnt_ff;
      held_rise_in = held_rise_ff;
      held_fall_in = held_fall_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_in = job_data;
               state_in = job_data.interp ? ST_PREP : ST_OUT;
            end
         end
         ST_PREP: begin
            p_in = diff_p[AMP_W-1:0];
            den_in = diff_d[AMP_W-1:0];
            neg_in = dt[TIME_W];
            dmag_in = dt_abs[TIME_W-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            rem_in = prod[PROD_W-1:TIME_W];
            low_in = prod[TIME_W-1:0];
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? AMP_W'(shifted - {1'b0, den_ff}) : shifted[AMP_W-1:0];
            low_in = {low_ff[TIME_W-2:0], ge};
            if (cnt_ff == CNT_W'(TIME_W - 1)) begin
               state_in = ST_FIX;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIX: begin
            if (job_ff.is_rise) begin
               held_rise_in = t_new;
            end else begin
               held_fall_in = t_new;
            end
            state_in = job_ff.finish ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      p_ff <= p_in;
      den_ff <= den_in;
      dmag_ff <= dmag_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
      held_rise_ff <= held_rise_in;
      held_fall_ff <= held_fall_in;
   end

endmodule

>>> test/time_over_threshold_interp_tb.sv
`timescale 1ns / 1ps
module time_over_threshold_interp_tb;
   import tot_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_COUNT = 14;
   localparam int PHASE_ITEMS = 55;
   localparam int LONG_PHASE = 4;
   localparam int SQUEEZE_PHASE = 5;
   localparam int HOLD_CYCLES = 800;
   localparam int MAX_SHOWN = 10;
   localparam int LONG_LENGTH = 1035;

   typedef enum logic [1:0] {SEEK_RISE, SEEK_FALL, PULSE_DONE} search_type;

   typedef struct packed {
      logic [TIME_W-1:0] t;
      logic signed [AMP_W-1:0] a;
      logic last;
      logic typed;
      tot_rsp_type want;
   } bench_row_type;

   // Hand-checked pulses first, then edge cases scored by the predictor:
   // full-scale swing with a fall rejected for coming before the rise time,
   // falling times, a rise on the final sample, amplitude equal to the
   // threshold, and a fall candidate at exactly the rise time.
   localparam bench_row_type DIRECTED_ROWS [23] = '{
      '{20'd0, -16'sd64, 1'b0, 1'b0, '0},
      '{20'd100, 16'sd64, 1'b0, 1'b0, '0},
      '{20'd200, 16'sd64, 1'b0, 1'b0, '0},
      '{20'd300, -16'sd64, 1'b1, 1'b1, '{1'b1, 20'd50, 20'd250}},
      '{20'hFFFFF, 16'sh8000, 1'b1, 1'b1, '{1'b0, 20'd0, 20'd0}},
      '{20'd0, 16'sh8000, 1'b0, 1'b0, '0},
      '{20'hFFFFF, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{20'd1000, 16'sh8000, 1'b1, 1'b0, '0},
      '{20'd500, -16'sd1, 1'b0, 1'b0, '0},
      '{20'd400, 16'sd2, 1'b0, 1'b0, '0},
      '{20'd600, 16'sd5, 1'b0, 1'b0, '0},
      '{20'd700, -16'sd3, 1'b1, 1'b0, '0},
      '{20'd10, -16'sd5, 1'b0, 1'b0, '0},
      '{20'd20, 16'sd5, 1'b1, 1'b0, '0},
      '{20'd0, -16'sd10, 1'b0, 1'b0, '0},
      '{20'd30, 16'sd0, 1'b0, 1'b0, '0},
      '{20'd40, 16'sd0, 1'b0, 1'b0, '0},
      '{20'd50, -16'sd1, 1'b1, 1'b0, '0},
      '{20'd0, -16'sd10, 1'b0, 1'b0, '0},
      '{20'd10, 16'sd10, 1'b0, 1'b0, '0},
      '{20'd5, -16'sd10, 1'b0, 1'b0, '0},
      '{20'd6, 16'sd10, 1'b0, 1'b0, '0},
      '{20'd7, -16'sd10, 1'b1, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   tot_req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   tot_rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the configuration and the per-waveform state.
   logic signed [AMP_W-1:0] thr_cfg = THRESHOLD_RESET;
   logic [WIN_W-1:0] first_cfg = WINDOW_FIRST_RESET;
   logic [WIN_W-1:0] last_cfg = WINDOW_LAST_RESET;
   logic signed [AMP_W-1:0] prev_amp = '0;
   logic [TIME_W-1:0] prev_time = '0;
   int unsigned sample_idx = 0;
   search_type phase = SEEK_RISE;
   logic [TIME_W-1:0] rise_hold = '0;
   logic [TIME_W-1:0] fall_hold = '0;

   tot_rsp_type awaited_pulses[$];
   int failures = 0;
   int pulses_seen = 0;
   int items_sent = 0;
   bit sender_quiet = 1'b0;
   bit hold_request = 1'b0;

   always #5 clock = ~clock;

   time_over_threshold_interp #(
      .WAVEFORM_LENGTH(TOT_WAVEFORM_LENGTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Exact floor of t0 + (thr - a0) * (t1 - t0) / (a1 - a0).
   function automatic logic [TIME_W-1:0] crossing_time(input logic [TIME_W-1:0] t0,
         input logic signed [AMP_W-1:0] a0, input logic [TIME_W-1:0] t1,
         input logic signed [AMP_W-1:0] a1);
      longint num;
      longint den;
      longint q;
      longint sum;
      num = (longint'(thr_cfg) - longint'(a0)) * (longint'(t1) - longint'(t0));
      den = longint'(a1) - longint'(a0);
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      q = num / den;
      if (num < 0 && (num % den) != 0) begin
         q = q - 1;
      end
      sum = longint'(t0) + q;
      return sum[TIME_W-1:0];
   endfunction

   function automatic bit predict_crossings(input tot_req_type s, output tot_rsp_type r);
      logic signed [AMP_W-1:0] amp;
      logic [TIME_W-1:0] t;
      bit open;
      amp = s.sample_amplitude;
      t = s.sample_time;
      open = sample_idx > first_cfg && sample_idx <= last_cfg &&
             sample_idx < TOT_WAVEFORM_LENGTH;
      if (open) begin
         if (phase == SEEK_RISE && prev_amp < thr_cfg && amp >= thr_cfg) begin
            rise_hold = crossing_time(prev_time, prev_amp, t, amp);
            phase = SEEK_FALL;
         end else if (phase == SEEK_FALL && t > rise_hold && prev_amp >= thr_cfg &&
                      amp < thr_cfg) begin
            fall_hold = crossing_time(prev_time, prev_amp, t, amp);
            phase = PULSE_DONE;
         end
      end
      prev_amp = amp;
      prev_time = t;
      if (sample_idx < TOT_WAVEFORM_LENGTH) begin
         sample_idx++;
      end
      r = '0;
      if (!s.last_sample) begin
         return 1'b0;
      end
      if (phase == PULSE_DONE) begin
         r.found = 1'b1;
         r.rise_time = rise_hold;
         r.fall_time = fall_hold;
      end
      sample_idx = 0;
      phase = SEEK_RISE;
      rise_hold = '0;
      fall_hold = '0;
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [AMP_W-1:0] clamp_amp(input int v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return v[AMP_W-1:0];
   endfunction

   task automatic send_sample(input tot_req_type s, input bit typed, input tot_rsp_type want);
      int gap;
      bit has_result;
      tot_rsp_type r;
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (req_full !== 1'b0);
      has_result = predict_crossings(s, r);
      if (has_result) begin
         awaited_pulses.insert(awaited_pulses.size(), typed ? want : r);
      end
      items_sent++;
   endtask

   // One waveform: a pulse over the threshold from rise_at up to fall_at, with
   // the odd glitch, or random noise when noisy is set.
   task automatic send_waveform(input int len, input int rise_at, input int fall_at,
         input bit noisy, input int step_max, input logic [TIME_W-1:0] start);
      tot_req_type s;
      logic [TIME_W-1:0] t;
      int span;
      bit high;
      case ($urandom_range(0, 2))
         0: span = $urandom_range(1, 8);
         1: span = $urandom_range(1, 2000);
         default: span = 65535;
      endcase
      t = start;
      for (int i = 0; i < len; i++) begin
         if (noisy) begin
            if ($urandom_range(0, 9) < 3) begin
               t = TIME_W'($urandom);
            end else begin
               t = t + TIME_W'($urandom_range(0, 100));
            end
            s.sample_amplitude = AMP_W'($urandom);
         end else begin
            if (i > 0) begin
               t = t + TIME_W'($urandom_range(1, step_max));
            end
            high = i >= rise_at && i < fall_at;
            if ($urandom_range(0, 99) < 4) begin
               high = !high;
            end
            if (high) begin
               s.sample_amplitude = clamp_amp(int'(thr_cfg) + int'($urandom_range(0, span)));
            end else begin
               s.sample_amplitude = clamp_amp(int'(thr_cfg) - int'($urandom_range(1, span)));
            end
         end
         s.sample_time = t;
         s.last_sample = i == len - 1;
         send_sample(s, 1'b0, '0);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_THRESHOLD: thr_cfg = val;
         CSR_WINDOW_FIRST: first_cfg = val[WIN_W-1:0];
         CSR_WINDOW_LAST: last_cfg = val[WIN_W-1:0];
         default: ;
      endcase
   endtask

   // Junk above bit 9: on last now and then, on first always; ten bits count.
   task automatic configure(input int thr, input int first, input int last);
      logic [CSR_DATA_W-WIN_W-1:0] junk;
      junk = $urandom_range(0, 1) ? (CSR_DATA_W - WIN_W)'($urandom) : '0;
      write_reg(CSR_WINDOW_LAST, {junk, last[WIN_W-1:0]});
      write_reg(CSR_THRESHOLD, thr[CSR_DATA_W-1:0]);
      write_reg(CSR_WINDOW_FIRST, {~junk, first[WIN_W-1:0]});
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (awaited_pulses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_pulse(input tot_rsp_type got);
      tot_rsp_type want;
      if (awaited_pulses.size() == 0) begin
         failures++;
         if (failures <= MAX_SHOWN) begin
            $display("%0t: unexpected item found=%0d rise=%0d fall=%0d", $realtime,
                     got.found, got.rise_time, got.fall_time);
         end
      end else begin
         want = awaited_pulses.pop_front();
         if (got.found !== want.found || got.rise_time !== want.rise_time ||
             got.fall_time !== want.fall_time) begin
            failures++;
            if (failures <= MAX_SHOWN) begin
               $display("%0t: expected found=%0d rise=%0d fall=%0d, got found=%0d rise=%0d fall=%0d",
                        $realtime, want.found, want.rise_time, want.fall_time,
                        got.found, got.rise_time, got.fall_time);
            end
         end
      end
      pulses_seen++;
   endtask

   // Result side: random stalls and bursts, plus one long hold-off on request.
   initial begin
      int stall_left;
      int burst_left;
      int hold_left;
      stall_left = 0;
      burst_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && rsp_empty === 1'b0) begin
            check_pulse(rsp_data);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               stall_left = pick_gap();
               burst_left = $urandom_range(0, 9) == 0 ? 200 : $urandom_range(0, 8);
            end
         end
      end
   end

   initial begin
      int thr;
      int first;
      int last;
      int base;
      int rise_at;
      int fall_at;
      int len;
      int phase_start;
      bit noisy;
      tot_req_type s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         s.sample_time = DIRECTED_ROWS[i].t;
         s.sample_amplitude = DIRECTED_ROWS[i].a;
         s.last_sample = DIRECTED_ROWS[i].last;
         send_sample(s, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         thr = int'($urandom_range(0, 4000)) - 2000;
         first = 0;
         last = 1023;
         case (p)
            0: thr = -32768;
            1: thr = 32767;
            2: first = 1023;
            3: last = 0;
            LONG_PHASE: first = $urandom_range(1000, 1010);
            default: begin
               if ($urandom_range(0, 9) < 3) begin
                  thr = int'($signed(16'($urandom)));
               end
               first = $urandom_range(0, 12);
               case ($urandom_range(0, 19))
                  0, 1, 2: last = 1023;
                  3, 4, 5: last = $urandom_range(0, first);
                  6, 7, 8, 9: last = first + 1;
                  default: last = first + $urandom_range(1, 40);
               endcase
            end
         endcase
         configure(thr, first, last);
         sender_quiet = p == SQUEEZE_PHASE || $urandom_range(0, 3) == 0;
         phase_start = items_sent;
         if (p == LONG_PHASE) begin
            // The pulse sits near the end of the index range, where the
            // sample counter saturates.
            rise_at = $urandom_range(1012, 1020);
            send_waveform(LONG_LENGTH, rise_at, rise_at + $urandom_range(2, 8), 1'b0, 300,
                          TIME_W'($urandom_range(0, 'h30000)));
         end
         if (p == SQUEEZE_PHASE) begin
            hold_request = 1'b1;
         end
         while (items_sent - phase_start < PHASE_ITEMS) begin
            base = first_cfg < 64 ? int'(first_cfg) : 0;
            noisy = p == SQUEEZE_PHASE || $urandom_range(0, 99) < 20;
            rise_at = base + $urandom_range(0, 5);
            fall_at = rise_at + $urandom_range(1, 25);
            if (p == SQUEEZE_PHASE) begin
               len = $urandom_range(1, 4);
            end else if (noisy) begin
               len = $urandom_range(1, 30);
            end else if ($urandom_range(0, 7) == 0) begin
               len = $urandom_range(1, fall_at);
            end else begin
               len = fall_at + $urandom_range(1, 6);
            end
            send_waveform(len, rise_at, fall_at, noisy,
                          $urandom_range(0, 1) ? 50 : 3000,
                          TIME_W'($urandom_range(0, 'hFFFFF)));
         end
         drain();
      end

      if (failures == 0) begin
         $display("[time_over_threshold_interp] OK");
      end else begin
         $display("[time_over_threshold_interp] ERROR");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("[time_over_threshold_interp] ERROR");
      $finish;
   end

endmodule
